// ----- design/ccd_pkg.sv -----
`default_nettype none

package ccd_pkg;

	// Number formats
	localparam int ACC_FRAC_BITS   = 16;
	localparam int POINT_FRAC_BITS = 30;
	localparam int ACC_W           = 64;
	localparam int WIDE_W          = 96;
	localparam int SH_W            = 7;

	// Coefficient products carry 16 fraction bits; align them to the accumulator format.
	localparam int COEF_UP   = (ACC_FRAC_BITS >= 16) ? (ACC_FRAC_BITS - 16) : 0;
	localparam int COEF_DOWN = (ACC_FRAC_BITS < 16) ? (16 - ACC_FRAC_BITS) : 0;

	// Shift after x*acc: the inner steps use 2x, the closing step uses x.
	localparam int SH_STEP = POINT_FRAC_BITS - 1;
	localparam int SH_END  = POINT_FRAC_BITS;

	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Sequencer
	localparam int PC_W = 5;
	typedef logic [PC_W-1:0] pc_t;
	localparam pc_t LAST_BASE = 5'd11;

	// Multiplier operand selection
	typedef logic [1:0] mul_op_t;
	localparam mul_op_t MUL_NONE = 2'd0;
	localparam mul_op_t MUL_COEF = 2'd1;
	localparam mul_op_t MUL_LO   = 2'd2;
	localparam mul_op_t MUL_HI   = 2'd3;

	// Accumulator whose magnitude is loaded for the next two partial products
	typedef logic [1:0] mag_src_t;
	localparam mag_src_t MAG_NONE = 2'd0;
	localparam mag_src_t MAG_B    = 2'd1;
	localparam mag_src_t MAG_D    = 2'd2;
	localparam mag_src_t MAG_S    = 2'd3;

	// Wide product register operation
	typedef logic [1:0] wide_op_t;
	localparam wide_op_t W_NONE  = 2'd0;
	localparam wide_op_t W_COEF  = 2'd1;
	localparam wide_op_t W_LOAD  = 2'd2;
	localparam wide_op_t W_ADDHI = 2'd3;

	// Floor shift and saturation of the wide product
	typedef logic [1:0] rnd_op_t;
	localparam rnd_op_t R_NONE = 2'd0;
	localparam rnd_op_t R_COEF = 2'd1;
	localparam rnd_op_t R_STEP = 2'd2;
	localparam rnd_op_t R_END  = 2'd3;

	// Saturating adder
	typedef logic [1:0] alu_op_t;
	localparam alu_op_t ALU_NONE = 2'd0;
	localparam alu_op_t ALU_SUB  = 2'd1;
	localparam alu_op_t ALU_ADD  = 2'd2;

	typedef logic [1:0] alu_dst_t;
	localparam alu_dst_t DST_B = 2'd0;
	localparam alu_dst_t DST_D = 2'd1;
	localparam alu_dst_t DST_S = 2'd2;

	typedef logic alu_a_t;
	localparam alu_a_t A_TERM = 1'b0;
	localparam alu_a_t A_DST  = 1'b1;

	typedef logic [2:0] alu_b_t;
	localparam alu_b_t B_B2   = 3'd0;
	localparam alu_b_t B_D2   = 3'd1;
	localparam alu_b_t B_S2   = 3'd2;
	localparam alu_b_t B_C    = 3'd3;
	localparam alu_b_t B_B1   = 3'd4;
	localparam alu_b_t B_B1X2 = 3'd5;
	localparam alu_b_t B_D1X2 = 3'd6;
	localparam alu_b_t B_D1X4 = 3'd7;

	// End of item action
	typedef logic [1:0] fin_t;
	localparam fin_t F_NONE   = 2'd0;
	localparam fin_t F_COMMIT = 2'd1;
	localparam fin_t F_EMIT   = 2'd2;

	typedef logic [1:0] jmp_t;
	localparam jmp_t J_NEXT = 2'd0;
	localparam jmp_t J_LAST = 2'd1;
	localparam jmp_t J_DONE = 2'd2;

	typedef struct packed {
		mul_op_t  mul;
		mag_src_t mag;
		wide_op_t wide;
		rnd_op_t  rnd;
		alu_op_t  alu;
		alu_dst_t dst;
		alu_a_t   a;
		alu_b_t   b;
		fin_t     fin;
		jmp_t     jmp;
	} uword_t;

	function automatic uword_t uw_make(mul_op_t mul, mag_src_t mag, wide_op_t wide,
			rnd_op_t rnd, alu_op_t alu, alu_dst_t dst, alu_a_t a, alu_b_t b,
			fin_t fin, jmp_t jmp);
		uword_t w;
		w.mul  = mul;
		w.mag  = mag;
		w.wide = wide;
		w.rnd  = rnd;
		w.alu  = alu;
		w.dst  = dst;
		w.a    = a;
		w.b    = b;
		w.fin  = fin;
		w.jmp  = jmp;
		return w;
	endfunction

	// Program: address 0 is shared, 1..10 run an inner coefficient, 11..20 close the run.
	function automatic uword_t ucode(pc_t pc);
		uword_t w;
		unique case (pc)
			5'd0:  w = uw_make(MUL_COEF, MAG_B, W_NONE, R_NONE, ALU_NONE, DST_B, A_TERM,
					B_B2, F_NONE, J_LAST);
			5'd1:  w = uw_make(MUL_LO, MAG_NONE, W_COEF, R_NONE, ALU_NONE, DST_B, A_TERM,
					B_B2, F_NONE, J_NEXT);
			5'd2:  w = uw_make(MUL_HI, MAG_D, W_LOAD, R_COEF, ALU_NONE, DST_B, A_TERM,
					B_B2, F_NONE, J_NEXT);
			5'd3:  w = uw_make(MUL_LO, MAG_NONE, W_ADDHI, R_NONE, ALU_NONE, DST_B, A_TERM,
					B_B2, F_NONE, J_NEXT);
			5'd4:  w = uw_make(MUL_HI, MAG_S, W_LOAD, R_STEP, ALU_NONE, DST_B, A_TERM,
					B_B2, F_NONE, J_NEXT);
			5'd5:  w = uw_make(MUL_LO, MAG_NONE, W_ADDHI, R_NONE, ALU_SUB, DST_B, A_TERM,
					B_B2, F_NONE, J_NEXT);
			5'd6:  w = uw_make(MUL_HI, MAG_NONE, W_LOAD, R_STEP, ALU_ADD, DST_B, A_DST,
					B_C, F_NONE, J_NEXT);
			5'd7:  w = uw_make(MUL_NONE, MAG_NONE, W_ADDHI, R_NONE, ALU_SUB, DST_D, A_TERM,
					B_D2, F_NONE, J_NEXT);
			5'd8:  w = uw_make(MUL_NONE, MAG_NONE, W_NONE, R_STEP, ALU_ADD, DST_D, A_DST,
					B_B1X2, F_NONE, J_NEXT);
			5'd9:  w = uw_make(MUL_NONE, MAG_NONE, W_NONE, R_NONE, ALU_SUB, DST_S, A_TERM,
					B_S2, F_NONE, J_NEXT);
			5'd10: w = uw_make(MUL_NONE, MAG_NONE, W_NONE, R_NONE, ALU_ADD, DST_S, A_DST,
					B_D1X4, F_COMMIT, J_DONE);
			5'd11: w = uw_make(MUL_LO, MAG_NONE, W_COEF, R_NONE, ALU_NONE, DST_B, A_TERM,
					B_B2, F_NONE, J_NEXT);
			5'd12: w = uw_make(MUL_HI, MAG_D, W_LOAD, R_COEF, ALU_NONE, DST_B, A_TERM,
					B_B2, F_NONE, J_NEXT);
			5'd13: w = uw_make(MUL_LO, MAG_NONE, W_ADDHI, R_NONE, ALU_NONE, DST_B, A_TERM,
					B_B2, F_NONE, J_NEXT);
			5'd14: w = uw_make(MUL_HI, MAG_S, W_LOAD, R_END, ALU_NONE, DST_B, A_TERM,
					B_B2, F_NONE, J_NEXT);
			5'd15: w = uw_make(MUL_LO, MAG_NONE, W_ADDHI, R_NONE, ALU_SUB, DST_B, A_TERM,
					B_B2, F_NONE, J_NEXT);
			5'd16: w = uw_make(MUL_HI, MAG_NONE, W_LOAD, R_END, ALU_ADD, DST_B, A_DST,
					B_C, F_NONE, J_NEXT);
			5'd17: w = uw_make(MUL_NONE, MAG_NONE, W_ADDHI, R_NONE, ALU_SUB, DST_D, A_TERM,
					B_D2, F_NONE, J_NEXT);
			5'd18: w = uw_make(MUL_NONE, MAG_NONE, W_NONE, R_END, ALU_ADD, DST_D, A_DST,
					B_B1, F_NONE, J_NEXT);
			5'd19: w = uw_make(MUL_NONE, MAG_NONE, W_NONE, R_NONE, ALU_SUB, DST_S, A_TERM,
					B_S2, F_NONE, J_NEXT);
			5'd20: w = uw_make(MUL_NONE, MAG_NONE, W_NONE, R_NONE, ALU_ADD, DST_S, A_DST,
					B_D1X2, F_EMIT, J_DONE);
			default: w = uw_make(MUL_NONE, MAG_NONE, W_NONE, R_NONE, ALU_NONE, DST_B,
					A_TERM, B_B2, F_NONE, J_DONE);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- design/ccd_datapath.sv -----
`default_nettype none

module ccd_datapath import ccd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire logic              step_en,
	input  wire uword_t            uw,
	input  wire logic [31:0]       coefficient,
	input  wire logic [31:0]       ref_coefficient,
	input  wire logic [31:0]       point,
	input  wire logic [31:0]       unit_scale,
	output logic      [ACC_W-1:0]  value,
	output logic      [ACC_W-1:0]  first_derivative,
	output logic      [ACC_W-1:0]  curvature,
	output logic                   overflow
);

	// Floor shift of a sign and magnitude product, saturated to 64 bits; bit 64 flags overflow.
	function automatic logic [ACC_W:0] rnd_sat(logic neg, logic [WIDE_W-1:0] mag,
			logic [SH_W-1:0] sh);
		logic [WIDE_W-1:0] q;
		logic              rem;
		logic [ACC_W:0]    r;
		q   = mag >> sh;
		rem = |(mag & ((({{(WIDE_W-1){1'b0}}, 1'b1}) << sh) - 1'b1));
		if (!neg) begin
			if (|q[WIDE_W-1:ACC_W-1])
				r = {1'b1, ACC_MAX};
			else
				r = {1'b0, q[ACC_W-1:0]};
		end else if (rem) begin
			// -(q + 1) is the bitwise complement of q.
			if (|q[WIDE_W-1:ACC_W-1])
				r = {1'b1, ACC_MIN};
			else
				r = {1'b0, ~q[ACC_W-1:0]};
		end else begin
			if ((|q[WIDE_W-1:ACC_W]) || (q[ACC_W-1] && (|q[ACC_W-2:0])))
				r = {1'b1, ACC_MIN};
			else
				r = {1'b0, -q[ACC_W-1:0]};
		end
		return r;
	endfunction

	// Saturating doubling.
	function automatic logic [ACC_W:0] dbl_sat(logic [ACC_W-1:0] v);
		logic [ACC_W:0] r;
		if (v[ACC_W-1] != v[ACC_W-2])
			r = {1'b1, (v[ACC_W-1] ? ACC_MIN : ACC_MAX)};
		else
			r = {1'b0, v[ACC_W-2:0], 1'b0};
		return r;
	endfunction

	// Run state
	logic              in_run_q;
	logic [31:0]       xmag_q;
	logic              xneg_q;
	logic              run_ovf_q;
	logic [ACC_W-1:0]  b1_q, b2_q, d1_q, d2_q, s1_q, s2_q;

	// Working registers
	logic [32:0]       msum_q;
	logic              csgn_q;
	logic [ACC_W-1:0]  magreg_q;
	logic              magneg_q;
	logic [63:0]       prod_q;
	logic [WIDE_W-1:0] wide_q;
	logic              wneg_q;
	logic [ACC_W-1:0]  c_q, term_q, rb_q, rd_q, rs_q;

	logic [32:0]       sum33;
	logic [31:0]       pmag;
	logic [ACC_W-1:0]  srcv;
	logic [31:0]       mul_a, mul_b;
	logic [WIDE_W-1:0] rmag;
	logic [SH_W-1:0]   rsh;
	logic [ACC_W:0]    rres;
	logic              rnd_ovf;
	logic [ACC_W:0]    b1x2, d1x2, d1x4;
	logic [ACC_W-1:0]  a_val, b_val, dst_val;
	logic              b_ovf;
	logic [ACC_W:0]    sum65;
	logic [ACC_W-1:0]  alu_res;
	logic              alu_ovf;
	logic              step_ovf;

	// Item operands: coefficient sum as sign and magnitude, point magnitude.
	assign sum33 = {coefficient[31], coefficient} + {ref_coefficient[31], ref_coefficient};
	assign pmag  = point[31] ? (32'd0 - point) : point;

	// Accumulator feeding the next pair of partial products.
	always_comb begin
		unique case (uw.mag)
			MAG_B:   srcv = b1_q;
			MAG_D:   srcv = d1_q;
			MAG_S:   srcv = s1_q;
			default: srcv = '0;
		endcase
	end

	// Shared 32x32 multiplier operands.
	always_comb begin
		unique case (uw.mul)
			MUL_COEF: mul_a = msum_q[31:0];
			MUL_HI:   mul_a = magreg_q[63:32];
			default:  mul_a = magreg_q[31:0];
		endcase
		mul_b = (uw.mul == MUL_COEF) ? unit_scale : xmag_q;
	end

	// Floor shift and saturation.
	always_comb begin
		rmag = (uw.rnd == R_COEF) ? (wide_q << COEF_UP) : wide_q;
		unique case (uw.rnd)
			R_COEF:  rsh = SH_W'(COEF_DOWN);
			R_STEP:  rsh = SH_W'(SH_STEP);
			default: rsh = SH_W'(SH_END);
		endcase
		rres    = rnd_sat(wneg_q, rmag, rsh);
		rnd_ovf = (uw.rnd != R_NONE) && rres[ACC_W];
	end

	// Saturating adder with its operand selection.
	always_comb begin
		b1x2 = dbl_sat(b1_q);
		d1x2 = dbl_sat(d1_q);
		d1x4 = dbl_sat(d1x2[ACC_W-1:0]);
		unique case (uw.dst)
			DST_D:   dst_val = rd_q;
			DST_S:   dst_val = rs_q;
			default: dst_val = rb_q;
		endcase
		a_val = (uw.a == A_DST) ? dst_val : term_q;
		unique case (uw.b)
			B_B2:   begin b_val = b2_q;              b_ovf = 1'b0;                   end
			B_D2:   begin b_val = d2_q;              b_ovf = 1'b0;                   end
			B_S2:   begin b_val = s2_q;              b_ovf = 1'b0;                   end
			B_C:    begin b_val = c_q;               b_ovf = 1'b0;                   end
			B_B1:   begin b_val = b1_q;              b_ovf = 1'b0;                   end
			B_B1X2: begin b_val = b1x2[ACC_W-1:0];   b_ovf = b1x2[ACC_W];            end
			B_D1X2: begin b_val = d1x2[ACC_W-1:0];   b_ovf = d1x2[ACC_W];            end
			B_D1X4: begin b_val = d1x4[ACC_W-1:0];   b_ovf = d1x2[ACC_W] | d1x4[ACC_W]; end
		endcase
		if (uw.alu == ALU_SUB)
			sum65 = {a_val[ACC_W-1], a_val} - {b_val[ACC_W-1], b_val};
		else
			sum65 = {a_val[ACC_W-1], a_val} + {b_val[ACC_W-1], b_val};
		if (sum65[ACC_W] != sum65[ACC_W-1])
			alu_res = sum65[ACC_W] ? ACC_MIN : ACC_MAX;
		else
			alu_res = sum65[ACC_W-1:0];
		alu_ovf  = (uw.alu != ALU_NONE) && (b_ovf || (sum65[ACC_W] != sum65[ACC_W-1]));
		step_ovf = rnd_ovf | alu_ovf;
	end

	// Closing results, valid in the emit step.
	assign value             = rb_q;
	assign first_derivative  = rd_q;
	assign curvature         = alu_res;
	assign overflow          = run_ovf_q | step_ovf;

	// Run state: latched point, recurrence history and sticky overflow.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q  <= 1'b0;
			xmag_q    <= '0;
			xneg_q    <= 1'b0;
			run_ovf_q <= 1'b0;
			b1_q      <= '0;
			b2_q      <= '0;
			d1_q      <= '0;
			d2_q      <= '0;
			s1_q      <= '0;
			s2_q      <= '0;
		end else if (load) begin
			if (!in_run_q) begin
				xmag_q <= pmag;
				xneg_q <= point[31];
			end
			in_run_q <= 1'b1;
		end else if (step_en) begin
			unique case (uw.fin)
				F_COMMIT: begin
					b2_q      <= b1_q;
					b1_q      <= rb_q;
					d2_q      <= d1_q;
					d1_q      <= rd_q;
					s2_q      <= s1_q;
					s1_q      <= alu_res;
					run_ovf_q <= run_ovf_q | step_ovf;
				end
				F_EMIT: begin
					in_run_q  <= 1'b0;
					xmag_q    <= '0;
					xneg_q    <= 1'b0;
					run_ovf_q <= 1'b0;
					b1_q      <= '0;
					b2_q      <= '0;
					d1_q      <= '0;
					d2_q      <= '0;
					s1_q      <= '0;
					s2_q      <= '0;
				end
				default: begin
					run_ovf_q <= run_ovf_q | step_ovf;
				end
			endcase
		end
	end

	// Working registers driven by the control word.
	always_ff @(posedge clk) begin
		if (load) begin
			csgn_q <= sum33[32];
			msum_q <= sum33[32] ? (33'd0 - sum33) : sum33;
		end
		if (step_en) begin
			if (uw.mag != MAG_NONE) begin
				magreg_q <= srcv[ACC_W-1] ? (ACC_W'(0) - srcv) : srcv;
				magneg_q <= srcv[ACC_W-1] ^ xneg_q;
			end
			if (uw.mul != MUL_NONE)
				prod_q <= {32'd0, mul_a} * {32'd0, mul_b};
			unique case (uw.wide)
				W_COEF: begin
					wide_q <= {32'd0, prod_q} +
						(msum_q[32] ? {32'd0, unit_scale, 32'd0} : {WIDE_W{1'b0}});
					wneg_q <= csgn_q;
				end
				W_LOAD: begin
					wide_q <= {32'd0, prod_q};
					wneg_q <= magneg_q;
				end
				W_ADDHI: begin
					wide_q <= wide_q + {prod_q, 32'd0};
				end
				default: begin
				end
			endcase
			if (uw.rnd == R_COEF)
				c_q <= rres[ACC_W-1:0];
			else if (uw.rnd != R_NONE)
				term_q <= rres[ACC_W-1:0];
			if (uw.alu != ALU_NONE) begin
				unique case (uw.dst)
					DST_D:   rd_q <= alu_res;
					DST_S:   rs_q <= alu_res;
					default: rb_q <= alu_res;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/chebyshev_clenshaw_deriv_eval.sv -----
// Chebyshev series evaluator with first and second derivative (Clenshaw recurrences).
// Input stream: one coefficient per transfer, highest index first; s_axis_tlast marks
// index 0. The point in s_axis_tdata is taken from the first transfer of a run only.
// Output stream: one transfer per run, after the transfer marked last, carrying value,
// first and second derivative in Q47.16 and a sticky overflow flag in m_axis_tuser.
// Configuration: cfg_data is written to the unit scale register (Q16.16, reset 1.0) at a
// cfg_valid/cfg_ready transfer; cfg_ready is always high. Write it only while idle.
// Operation: each item runs an eleven-step control program around one shared 32x32
// multiplier, which forms seven partial products per coefficient. s_axis_tready is low
// while the program runs, so a new item is taken only once the previous one is done.
// A result is registered onto m_axis_tvalid by the final step of the closing program.
// Stall: the output register holds a result until it is taken; the next run works up to
// its final step and waits there only while the previous result is still pending.
// Reset: arst_n clears the run state, the sequencer and the output valid, and sets the
// unit scale to 65536.
`default_nettype none

module chebyshev_clenshaw_deriv_eval import ccd_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [95:0]  s_axis_tdata,  // coefficient, ref_coefficient, point
	input  wire logic         s_axis_tlast,  // last (coefficient index 0)
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic      [191:0] m_axis_tdata,  // value, first_derivative, curvature
	output logic      [0:0]   m_axis_tuser,  // overflow
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [31:0]  cfg_data
);

	logic             busy_q;
	pc_t              pc_q;
	logic             last_q;
	logic [31:0]      unit_scale_q;
	logic             m_valid_q;
	logic [191:0]     m_data_q;
	logic             m_ovf_q;

	uword_t           uw;
	logic             accept;
	logic             stall;
	logic             step_en;
	logic             emit_go;
	logic [ACC_W-1:0] res_value, res_first, res_second;
	logic             res_ovf;

	// Control word of the current step.
	assign uw      = ucode(pc_q);
	assign accept  = s_axis_tvalid & s_axis_tready;
	assign stall   = (uw.fin == F_EMIT) && m_valid_q && !m_axis_tready;
	assign step_en = busy_q && !stall;
	assign emit_go = step_en && (uw.fin == F_EMIT);

	assign s_axis_tready = !busy_q;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_ovf_q;

	// Step counter with conditional jump.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
			last_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
			pc_q   <= '0;
			last_q <= s_axis_tlast;
		end else if (step_en) begin
			unique case (uw.jmp)
				J_LAST:  pc_q <= last_q ? LAST_BASE : (pc_q + 1'b1);
				J_DONE:  busy_q <= 1'b0;
				default: pc_q <= pc_q + 1'b1;
			endcase
		end
	end

	// Unit scale register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			unit_scale_q <= 32'd65536;
		else if (cfg_valid && cfg_ready)
			unit_scale_q <= cfg_data;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (emit_go)
			m_valid_q <= 1'b1;
		else if (m_axis_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			m_data_q <= {res_second, res_first, res_value};
			m_ovf_q  <= res_ovf;
		end
	end

	ccd_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.load              (accept),
		.step_en           (step_en),
		.uw                (uw),
		.coefficient       (s_axis_tdata[31:0]),
		.ref_coefficient   (s_axis_tdata[63:32]),
		.point             (s_axis_tdata[95:64]),
		.unit_scale        (unit_scale_q),
		.value             (res_value),
		.first_derivative  (res_first),
		.curvature         (res_second),
		.overflow          (res_ovf)
	);

endmodule

`default_nettype wire

// ----- design/ccd_checker.sv -----
`default_nettype none

module ccd_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [191:0] m_axis_tdata
);

	// An accepted item keeps the input closed while its program runs.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input ready right after a transfer");

	// A result only appears at the end of a program, when the input is closed.
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without an item in work");

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// A stalled result keeps its data.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result data changed while stalled");

endmodule

bind chebyshev_clenshaw_deriv_eval ccd_checker u_ccd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
